@@ design/particle_integration_step_assert.svh @@
// assertion macros for the particle integration block
// expects clk and rst_n in the scope of each use
`ifndef PARTICLE_INTEGRATION_STEP_ASSERT_SVH
`define PARTICLE_INTEGRATION_STEP_ASSERT_SVH
`ifndef ASSERT_OFF
`define PIS_ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PIS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define PIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PIS_ASSERT_HOLDS(lbl, prop, msg)
`define PIS_ASSERT_IMPLY(lbl, ante, cons, msg)
`define PIS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ design/pis_pkg.sv @@
// shared types, codes and helpers for the particle integration block
// no dependencies
`default_nettype none
package pis_pkg;
  localparam int unsigned MAX_PARTICLES_DEF = 64;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_PART  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic [1:0] CFG_ACC_X_EN = 2'd0;
  localparam logic [1:0] CFG_ACC_Y_EN = 2'd1;
  localparam logic [1:0] CFG_FRAMES   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACK, ST_UPD_RD, ST_UPD_MUL1, ST_UPD_VEL, ST_UPD_MUL2, ST_UPD_WR,
    ST_EMIT_RD, ST_EMIT_PREP, ST_EMIT_DIV, ST_EMIT_OUT
  } pis_state_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] acc_x;
    logic signed [23:0] acc_y;
    logic signed [24:0] life;
    logic [23:0]        max_life;
  } particle_t;

  function automatic logic signed [23:0] sat24(input logic signed [25:0] x);
    logic signed [23:0] r;
    if (x > 26'sd8388607) r = 24'sh7fffff;
    else if (x < -26'sd8388608) r = 24'sh800000;
    else r = x[23:0];
    return r;
  endfunction
endpackage
`default_nettype wire

@@ design/pis_frame_div.sv @@
// restoring divider for the frame index, one quotient bit per cycle
// depends on nothing; quotient is known to fit in eight bits
`default_nettype none
module pis_frame_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [23:0] divisor,
  output logic             done,
  output logic [7:0]       quotient
);
  logic [23:0] rem_r;
  logic [7:0]  lo_r;
  logic [7:0]  q_r;
  logic [23:0] dv_r;
  logic [2:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [24:0] trial;
  logic        ge;

  assign trial = {rem_r, lo_r[7]};
  assign ge    = trial >= {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // top bits are already below the divisor
      rem_r <= dividend[31:8];
      lo_r  <= dividend[7:0];
      dv_r  <= divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? 24'(trial - {1'b0, dv_r}) : trial[23:0];
      lo_r  <= {lo_r[6:0], 1'b0};
      q_r   <= {q_r[6:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule
`default_nettype wire

@@ design/particle_integration_step.sv @@
// top level of the particle integration block: particle memory, sequencer
// depends on pis_pkg, pis_frame_div and particle_integration_step_assert.svh
`default_nettype none
`include "particle_integration_step_assert.svh"
// Clear and load are answered from an acknowledge state that waits out any output
// stall. A step makes two passes over the particle memory (one 193-bit word per
// slot, registered read): an update pass per alive particle of read, a*dt,
// velocity, v*dt and write-back, then an emit pass per particle of read, frame
// preparation, the bit-serial divider when the frame index needs it, and output.
// Results of a step leave only after the whole update pass, since each carries
// the alive count that pass settles. No new item is taken until the last result
// of the current one is in the output register.
module particle_integration_step #(
  parameter int unsigned MAX_PARTICLES = pis_pkg::MAX_PARTICLES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [15:0] in_dt,
  input  wire logic signed [23:0] in_pos_x,
  input  wire logic signed [23:0] in_pos_y,
  input  wire logic signed [23:0] in_vel_x,
  input  wire logic signed [23:0] in_vel_y,
  input  wire logic signed [23:0] in_acc_x,
  input  wire logic signed [23:0] in_acc_y,
  input  wire logic [23:0] in_life,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [5:0]       out_slot,
  output logic signed [23:0] out_pos_x,
  output logic signed [23:0] out_pos_y,
  output logic [7:0]       out_frame_index,
  output logic [6:0]       out_alive_count,
  output logic             out_ended,
  output logic             out_error,
  output logic             out_last
);
  import pis_pkg::*;

  localparam int unsigned IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

  pis_state_t state_r, state_nxt;

  logic        acc_x_en_r, acc_y_en_r;
  logic [7:0]  frames_r;
  logic [6:0]  count_r;
  logic        ended_r;
  logic [6:0]  idx_r, n_r, first_r;
  logic        found_r;
  logic [15:0] dt_r;
  logic [1:0]  ack_kind_r;
  logic [5:0]  ack_slot_r;
  logic        ack_err_r;
  logic [7:0]  frame_r;
  particle_t   w_r;
  particle_t   rd_r;
  logic signed [40:0] pa_x_r, pa_y_r, pv_x_r, pv_y_r;

  particle_t   mem [MAX_PARTICLES];
  logic        mem_we;
  logic [IDX_W-1:0] mem_wa, mem_ra;
  particle_t   mem_wd;

  logic in_acc, out_free, out_load, is_last;
  logic full, load_ok;
  logic div_start, div_done;
  logic [7:0] div_q;
  logic signed [25:0] num;
  logic [31:0] div_dividend;
  logic [7:0]  prep_frame;
  logic        prep_special;
  logic signed [25:0] px_sum, py_sum, vx_sum, vy_sum, life_sub;
  logic signed [23:0] vx_new, vy_new;
  logic signed [24:0] life_new;
  particle_t   upd_word, load_word;
  logic signed [16:0] dt_s;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign full     = count_r >= 7'(MAX_PARTICLES);
  assign load_ok  = in_acc && (in_command == CMD_LOAD) && !full;
  assign is_last  = (idx_r + 7'd1) == n_r;
  assign dt_s     = $signed({1'b0, dt_r});

  // update pass arithmetic
  assign vx_sum = 26'(w_r.vel_x) + 26'(pa_x_r >>> 16);
  assign vy_sum = 26'(w_r.vel_y) + 26'(pa_y_r >>> 16);
  assign vx_new = acc_x_en_r ? sat24(vx_sum) : w_r.vel_x;
  assign vy_new = acc_y_en_r ? sat24(vy_sum) : w_r.vel_y;
  assign px_sum = 26'(w_r.pos_x) + 26'(pv_x_r >>> 16);
  assign py_sum = 26'(w_r.pos_y) + 26'(pv_y_r >>> 16);
  assign life_sub = 26'(w_r.life) - 26'($signed({1'b0, dt_r}));
  assign life_new = (life_sub < -26'sd16777216) ? 25'sh1000000 : life_sub[24:0];

  always_comb begin
    upd_word       = w_r;
    upd_word.pos_x = sat24(px_sum);
    upd_word.pos_y = sat24(py_sum);
    upd_word.life  = life_new;
  end

  always_comb begin
    load_word.pos_x    = in_pos_x;
    load_word.pos_y    = in_pos_y;
    load_word.vel_x    = in_vel_x;
    load_word.vel_y    = in_vel_y;
    load_word.acc_x    = in_acc_x;
    load_word.acc_y    = in_acc_y;
    load_word.max_life = in_life;
    load_word.life     = $signed({1'b0, in_life});
  end

  // frame index: special cases settle without the divider
  assign num          = $signed({2'b00, rd_r.max_life}) - 26'(rd_r.life);
  assign div_dividend = 32'(num[23:0]) * 32'(frames_r);
  always_comb begin
    prep_special = 1'b1;
    prep_frame   = '0;
    if (frames_r == 8'd0) prep_frame = '0;
    else if (rd_r.max_life == 24'd0) prep_frame = frames_r - 8'd1;
    else if (num <= 26'sd0) prep_frame = '0;
    else if (num >= $signed({2'b00, rd_r.max_life})) prep_frame = frames_r - 8'd1;
    else prep_special = 1'b0;
  end

  pis_frame_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (rd_r.max_life),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_command == CMD_STEP && count_r != 7'd0) state_nxt = ST_UPD_RD;
          else state_nxt = ST_ACK;
        end
      end
      ST_ACK:       if (out_free) state_nxt = ST_IDLE;
      ST_UPD_RD:    state_nxt = ST_UPD_MUL1;
      ST_UPD_MUL1:  state_nxt = ST_UPD_VEL;
      ST_UPD_VEL:   state_nxt = ST_UPD_MUL2;
      ST_UPD_MUL2:  state_nxt = ST_UPD_WR;
      ST_UPD_WR:    state_nxt = is_last ? ST_EMIT_RD : ST_UPD_RD;
      ST_EMIT_RD:   state_nxt = ST_EMIT_PREP;
      ST_EMIT_PREP: state_nxt = prep_special ? ST_EMIT_OUT : ST_EMIT_DIV;
      ST_EMIT_DIV:  if (div_done) state_nxt = ST_EMIT_OUT;
      ST_EMIT_OUT:  if (out_free) state_nxt = is_last ? ST_IDLE : ST_EMIT_RD;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wa    = idx_r[IDX_W-1:0];
    mem_wd    = upd_word;
    mem_ra    = idx_r[IDX_W-1:0];
    out_load  = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        mem_we = load_ok;
        mem_wa = count_r[IDX_W-1:0];
        mem_wd = load_word;
      end
      ST_ACK:       out_load = out_free;
      ST_UPD_WR:    mem_we = 1'b1;
      ST_EMIT_PREP: div_start = !prep_special;
      ST_EMIT_OUT:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      acc_x_en_r <= 1'b0;
      acc_y_en_r <= 1'b0;
      frames_r   <= 8'd1;
      count_r    <= '0;
      ended_r    <= 1'b0;
      out_valid  <= 1'b0;
      idx_r      <= '0;
      found_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ACC_X_EN: acc_x_en_r <= cfg_data[0];
          CFG_ACC_Y_EN: acc_y_en_r <= cfg_data[0];
          CFG_FRAMES:   frames_r   <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      if (in_acc) begin
        idx_r   <= '0;
        found_r <= 1'b0;
        if (in_command == CMD_CLEAR) begin
          count_r <= '0;
          ended_r <= 1'b0;
        end else if (load_ok) begin
          count_r <= count_r + 7'd1;
        end
      end
      if (state_r == ST_UPD_WR) begin
        if (!found_r && life_new <= 25'sd0) found_r <= 1'b1;
        if (is_last) begin
          idx_r <= '0;
          // alive count shrinks to the first spent slot
          if (!found_r && life_new <= 25'sd0) begin
            count_r <= idx_r;
            if (idx_r == 7'd0) ended_r <= 1'b1;
          end else if (found_r) begin
            count_r <= first_r;
            if (first_r == 7'd0) ended_r <= 1'b1;
          end
        end else begin
          idx_r <= idx_r + 7'd1;
        end
      end
      if (state_r == ST_EMIT_OUT && out_free && !is_last) idx_r <= idx_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dt_r       <= in_dt;
      n_r        <= count_r;
      ack_slot_r <= load_ok ? 6'(count_r) : 6'd0;
      ack_err_r  <= (in_command == CMD_LOAD) && full;
      ack_kind_r <= (in_command == CMD_STEP) ? KIND_EMPTY : KIND_ACK;
    end
    if (state_r == ST_UPD_WR && !found_r) first_r <= idx_r;
    if (state_r == ST_UPD_MUL1) begin
      w_r    <= rd_r;
      pa_x_r <= rd_r.acc_x * dt_s;
      pa_y_r <= rd_r.acc_y * dt_s;
    end
    if (state_r == ST_UPD_VEL) begin
      w_r.vel_x <= vx_new;
      w_r.vel_y <= vy_new;
    end
    if (state_r == ST_UPD_MUL2) begin
      pv_x_r <= w_r.vel_x * dt_s;
      pv_y_r <= w_r.vel_y * dt_s;
    end
    if (state_r == ST_EMIT_PREP) frame_r <= prep_frame;
    if (state_r == ST_EMIT_DIV && div_done) frame_r <= div_q;
    if (out_load) begin
      out_alive_count <= count_r;
      out_ended       <= ended_r;
      if (state_r == ST_ACK) begin
        out_kind        <= ack_kind_r;
        out_slot        <= ack_slot_r;
        out_pos_x       <= '0;
        out_pos_y       <= '0;
        out_frame_index <= '0;
        out_error       <= ack_err_r;
        out_last        <= 1'b1;
      end else begin
        out_kind        <= KIND_PART;
        out_slot        <= 6'(idx_r);
        out_pos_x       <= rd_r.pos_x;
        out_pos_y       <= rd_r.pos_y;
        out_frame_index <= frame_r;
        out_error       <= 1'b0;
        out_last        <= is_last;
      end
    end
  end

  `PIS_ASSERT_HOLDS(a_count_range, count_r <= 7'(MAX_PARTICLES), "alive count beyond table")
  `PIS_ASSERT_IMPLY(a_we_states, mem_we, state_r == ST_IDLE || state_r == ST_UPD_WR,
                    "memory written outside load or write-back")
  `PIS_ASSERT_IMPLY(a_ended_zero, $rose(ended_r), count_r == 7'd0, "ended without empty table")
  `PIS_ASSERT_NEXT(a_last_idle, out_load && state_r == ST_EMIT_OUT && is_last,
                   state_r == ST_IDLE, "emit pass did not finish on last result")
endmodule
`default_nettype wire

@@ bench/pis_checker.sv @@
// scoreboard for the particle integration block: watches config, input and result beats
// depends on pis_pkg for the command, kind and register codes
`timescale 1ns / 1ps
module pis_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_command,
  input  logic [15:0]       in_dt,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_vel_x,
  input  logic signed [23:0] in_vel_y,
  input  logic signed [23:0] in_acc_x,
  input  logic signed [23:0] in_acc_y,
  input  logic [23:0]       in_life,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        out_kind,
  input  logic [5:0]        out_slot,
  input  logic signed [23:0] out_pos_x,
  input  logic signed [23:0] out_pos_y,
  input  logic [7:0]        out_frame_index,
  input  logic [6:0]        out_alive_count,
  input  logic              out_ended,
  input  logic              out_error,
  input  logic              out_last,
  output int                fail_count,
  output int                pending
);
  import pis_pkg::*;

  localparam int TABLE_SIZE = 64;

  typedef struct {
    logic [1:0]        kind;
    logic [5:0]        slot;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [7:0]        frame;
    logic [6:0]        alive;
    logic              ended;
    logic              error;
    logic              last;
  } result_t;

  result_t awaited_results[$];

  logic signed [23:0] tab_px[TABLE_SIZE];
  logic signed [23:0] tab_py[TABLE_SIZE];
  logic signed [23:0] tab_vx[TABLE_SIZE];
  logic signed [23:0] tab_vy[TABLE_SIZE];
  logic signed [23:0] tab_ax[TABLE_SIZE];
  logic signed [23:0] tab_ay[TABLE_SIZE];
  logic signed [24:0] tab_life[TABLE_SIZE];
  logic [23:0]        tab_max[TABLE_SIZE];
  logic [6:0]         live_count;
  logic               ended_bit;
  logic               acc_x_on;
  logic               acc_y_on;
  logic [7:0]         frames;

  function automatic longint clip24(longint x);
    if (x > 64'sd8388607) return 64'sd8388607;
    if (x < -64'sd8388608) return -64'sd8388608;
    return x;
  endfunction

  // v + floor(m*dt / 2^16), saturated
  function automatic logic signed [23:0] euler_add(logic signed [23:0] base,
                                                   logic signed [23:0] m, longint dt);
    longint prod;
    prod = longint'(m) * dt;
    return 24'(clip24(longint'(base) + (prod >>> 16)));
  endfunction

  function automatic logic [7:0] anim_frame(logic signed [24:0] life, logic [23:0] maxl);
    longint num;
    longint q;
    if (frames == 0) return 8'd0;
    if (maxl == 0) return frames - 8'd1;
    num = longint'(maxl) - longint'(life);
    if (num <= 0) return 8'd0;
    q = (num * longint'(frames)) / longint'(maxl);
    if (q > longint'(frames) - 1) q = longint'(frames) - 1;
    return 8'(q);
  endfunction

  function automatic result_t ack_result(logic [5:0] slot, logic err);
    result_t r;
    r.kind = KIND_ACK; r.slot = slot; r.pos_x = '0; r.pos_y = '0; r.frame = '0;
    r.alive = live_count; r.ended = ended_bit; r.error = err; r.last = 1'b1;
    return r;
  endfunction

  task automatic advance_table(longint dt);
    int n;
    longint l;
    result_t r;
    n = live_count;
    for (int i = 0; i < n; i++) begin
      if (acc_x_on) tab_vx[i] = euler_add(tab_vx[i], tab_ax[i], dt);
      if (acc_y_on) tab_vy[i] = euler_add(tab_vy[i], tab_ay[i], dt);
      tab_px[i] = euler_add(tab_px[i], tab_vx[i], dt);
      tab_py[i] = euler_add(tab_py[i], tab_vy[i], dt);
      l = longint'(tab_life[i]) - dt;
      if (l < -64'sd16777216) l = -64'sd16777216;
      tab_life[i] = 25'(l);
    end
    // count shrinks to the first dead slot, even if later ones live
    for (int i = 0; i < n; i++) begin
      if (tab_life[i] <= 0) begin
        live_count = 7'(i);
        if (i == 0) ended_bit = 1'b1;
        break;
      end
    end
    for (int i = 0; i < n; i++) begin
      r.kind = KIND_PART; r.slot = 6'(i); r.pos_x = tab_px[i]; r.pos_y = tab_py[i];
      r.frame = anim_frame(tab_life[i], tab_max[i]);
      r.alive = live_count; r.ended = ended_bit; r.error = 1'b0;
      r.last = (i + 1 == n);
      awaited_results.push_back(r);
    end
  endtask

  task automatic predict_beat();
    result_t r;
    int s;
    case (in_command)
      CMD_CLEAR: begin
        live_count = '0;
        ended_bit = 1'b0;
        awaited_results.push_back(ack_result(6'd0, 1'b0));
      end
      CMD_LOAD: begin
        s = live_count;
        if (s >= TABLE_SIZE) begin
          awaited_results.push_back(ack_result(6'd0, 1'b1));
        end else begin
          tab_px[s] = in_pos_x; tab_py[s] = in_pos_y;
          tab_vx[s] = in_vel_x; tab_vy[s] = in_vel_y;
          tab_ax[s] = in_acc_x; tab_ay[s] = in_acc_y;
          tab_max[s] = in_life;
          tab_life[s] = {1'b0, in_life};
          live_count = 7'(s + 1);
          awaited_results.push_back(ack_result(6'(s), 1'b0));
        end
      end
      CMD_STEP: begin
        if (live_count == 0) begin
          r = ack_result(6'd0, 1'b0);
          r.kind = KIND_EMPTY;
          awaited_results.push_back(r);
        end else begin
          advance_table(longint'(in_dt));
        end
      end
      default: awaited_results.push_back(ack_result(6'd0, 1'b0));
    endcase
  endtask

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t w;
    if (!rst_n) begin
      awaited_results.delete();
      live_count = '0;
      ended_bit = 1'b0;
      acc_x_on = 1'b0;
      acc_y_on = 1'b0;
      frames = 8'd1;
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ACC_X_EN: acc_x_on = cfg_data[0];
          CFG_ACC_Y_EN: acc_y_on = cfg_data[0];
          CFG_FRAMES:   frames = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, kind %0d slot %0d",
                   $time, out_kind, out_slot);
        end else begin
          w = awaited_results.pop_front();
          compare_field("kind", w.kind, out_kind);
          compare_field("slot", w.slot, out_slot);
          compare_field("pos_x", w.pos_x, out_pos_x);
          compare_field("pos_y", w.pos_y, out_pos_y);
          compare_field("frame_index", w.frame, out_frame_index);
          compare_field("alive_count", w.alive, out_alive_count);
          compare_field("ended", w.ended, out_ended);
          compare_field("error", w.error, out_error);
          compare_field("last", w.last, out_last);
        end
      end
      // predict after the result check so a same-edge result is not matched early
      if (in_valid && !in_stall) predict_beat();
    end
    pending = awaited_results.size();
  end
endmodule

@@ bench/tb_particle_integration_step.sv @@
// stimulus and verdict for the particle integration block
// depends on pis_pkg, particle_integration_step and pis_checker
`timescale 1ns / 1ps
module tb_particle_integration_step;
  import pis_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_command = '0;
  logic [15:0] in_dt = '0;
  logic signed [23:0] in_pos_x = '0, in_pos_y = '0, in_vel_x = '0, in_vel_y = '0;
  logic signed [23:0] in_acc_x = '0, in_acc_y = '0;
  logic [23:0] in_life = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [5:0] out_slot;
  logic signed [23:0] out_pos_x, out_pos_y;
  logic [7:0] out_frame_index;
  logic [6:0] out_alive_count;
  logic out_ended, out_error, out_last;
  int fail_count;
  int pending;
  int cycles = 0;
  bit quiet_phase = 1'b0;

  particle_integration_step DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command), .in_dt(in_dt),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_vel_x(in_vel_x), .in_vel_y(in_vel_y),
    .in_acc_x(in_acc_x), .in_acc_y(in_acc_y), .in_life(in_life),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind), .out_slot(out_slot),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_frame_index(out_frame_index),
    .out_alive_count(out_alive_count), .out_ended(out_ended), .out_error(out_error),
    .out_last(out_last)
  );

  pis_checker u_checker (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_particle_integration_step: errors");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // receiver back-pressure: bursts of stall with calm stretches between
  initial begin
    int len;
    forever begin
      @(negedge clk);
      if (quiet_phase || $urandom_range(0, 3) == 0) begin
        out_stall = 1'b0;
        repeat ($urandom_range(1, 40)) @(negedge clk);
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 3);
        out_stall = 1'b1;
        repeat (len) @(negedge clk);
        out_stall = 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_beat(logic [1:0] cmd, logic [15:0] dt, logic [23:0] px,
                           logic [23:0] py, logic [23:0] vx, logic [23:0] vy,
                           logic [23:0] ax, logic [23:0] ay, logic [23:0] life);
    int g;
    in_command = cmd; in_dt = dt; in_pos_x = px; in_pos_y = py;
    in_vel_x = vx; in_vel_y = vy; in_acc_x = ax; in_acc_y = ay; in_life = life;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic send_cmd(logic [1:0] cmd, logic [15:0] dt);
    send_beat(cmd, dt, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
              24'($urandom), 24'($urandom), 24'($urandom));
  endtask

  task automatic load_random(bit short_lived);
    logic [23:0] life;
    life = short_lived ? 24'($urandom_range(1, 180000)) : 24'($urandom);
    send_beat(CMD_LOAD, 16'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
              24'($urandom), 24'($urandom), 24'($urandom), life);
  endtask

  function automatic logic [15:0] random_dt();
    case ($urandom_range(0, 5))
      0: return 16'hffff;
      1: return 16'd0;
      2: return 16'($urandom_range(1, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic set_regs(logic ax, logic ay, logic [7:0] fc);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we = 1'b1; cfg_index = CFG_ACC_X_EN; cfg_data = {7'($urandom), ax};
    @(negedge clk);
    cfg_index = CFG_ACC_Y_EN; cfg_data = {7'($urandom), ay};
    @(negedge clk);
    cfg_index = CFG_FRAMES; cfg_data = fc;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    int loads;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed part
    quiet_phase = 1'b1;
    set_regs(1'b1, 1'b0, 8'd255);
    send_cmd(CMD_STEP, 16'd100);
    send_cmd(2'd3, 16'd0);
    send_beat(CMD_LOAD, 16'hffff, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff,
              24'h7fffff, 24'h7fffff, 24'hffffff);
    send_beat(CMD_LOAD, 16'h0000, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
              24'h800000, 24'h800000, 24'h000001);
    send_beat(CMD_LOAD, 16'h1234, 24'h000100, 24'hffff00, 24'hfff000, 24'h001000,
              24'h000800, 24'hfff800, 24'h000000);
    send_beat(CMD_LOAD, 16'h0001, 24'h0, 24'h0, 24'h400000, 24'hc00000,
              24'h7fffff, 24'h800000, 24'h800000);
    // unsorted lifetimes: slot 2 dies first, slot 0 keeps going
    send_cmd(CMD_STEP, 16'd0);
    send_cmd(CMD_STEP, 16'hffff);
    send_cmd(CMD_STEP, 16'hffff);
    set_regs(1'b0, 1'b1, 8'd0);
    send_cmd(CMD_STEP, 16'h8000);
    send_cmd(CMD_CLEAR, 16'hffff);
    send_beat(CMD_LOAD, 16'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h000000);
    send_cmd(CMD_STEP, 16'd5);
    send_cmd(CMD_STEP, 16'd5);
    send_cmd(2'd3, 16'hffff);
    send_cmd(CMD_CLEAR, 16'd0);
    set_regs(1'b1, 1'b1, 8'd1);
    load_random(1'b1);
    send_cmd(CMD_STEP, 16'hffff);

    // random phases of well-formed sequences with some noise
    for (int ph = 0; ph < 4; ph++) begin
      quiet_phase = (ph == 3);
      case (ph)
        0: set_regs(1'b0, 1'b0, 8'd255);
        1: set_regs(1'b1, 1'b1, 8'd1);
        default: set_regs(1'($urandom), 1'($urandom), 8'($urandom_range(1, 255)));
      endcase
      send_cmd(CMD_CLEAR, 16'($urandom));
      loads = (ph == 2) ? 64 : $urandom_range(1, 8);
      for (int k = 0; k < loads; k++) load_random($urandom_range(0, 3) != 0);
      if (ph == 2) load_random(1'b0);
      for (int s = 0; s < 4; s++) begin
        if ($urandom_range(0, 7) == 0) send_cmd(2'd3, 16'($urandom));
        if ($urandom_range(0, 7) == 0) load_random(1'b1);
        send_cmd(CMD_STEP, random_dt());
      end
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_particle_integration_step: clean");
    end else begin
      $display("tb_particle_integration_step: errors");
    end
    $finish;
  end
endmodule
